// ===== rtl/stx_etx_lrc_frame_receiver_macros.svh =====
// Assertion macros for the STX/ETX/LRC frame receiver checker.
`ifndef STX_ETX_LRC_FRAME_RECEIVER_MACROS_SVH
`define STX_ETX_LRC_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SXLRC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SXLRC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sxlrc_pkg.sv =====
`default_nettype none

package sxlrc_pkg;

  localparam logic [7:0] SYM_STX = 8'h02;
  localparam logic [7:0] SYM_ETX = 8'h03;
  localparam logic [7:0] CH_Q    = 8'h51;
  localparam logic [7:0] CH_1    = 8'h31;
  localparam logic [7:0] CH_R    = 8'h52;
  localparam logic [7:0] CH_E    = 8'h45;
  localparam logic [7:0] CH_K    = 8'h4B;

  localparam int          APB_AW        = 3;
  localparam logic        REG_MAX_LEN   = 1'b0;
  localparam logic [3:0]  MAX_LEN_RESET = 4'd8;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_LRC_ERR  = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RT_Q1      = 2'd0,
    RT_RQ      = 2'd1,
    RT_EK      = 2'd2,
    RT_UNKNOWN = 2'd3
  } route_t;

  typedef struct packed {
    logic    valid;
    status_t status;
  } done_t;

  function automatic route_t classify(input logic [7:0] a, input logic [7:0] b);
    route_t r;
    r = RT_UNKNOWN;
    if (a == CH_Q && b == CH_1) r = RT_Q1;
    else if (a == CH_R && b == CH_Q) r = RT_RQ;
    else if (a == CH_E && b == CH_K) r = RT_EK;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sxlrc_ifs.sv =====
`default_nettype none

interface sxlrc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sxlrc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] frame_status;
  logic [1:0] route;
  logic       data_valid;
  logic [7:0] data_byte;
  logic [2:0] data_index;
  logic       last;

  modport source (output valid, output frame_status, output route, output data_valid,
                  output data_byte, output data_index, output last, input ready);
  modport sink   (input valid, input frame_status, input route, input data_valid,
                  input data_byte, input data_index, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/stx_etx_lrc_frame_receiver.sv =====
// Channel | Dir | Payload                                          | Transfer
// rx      | in  | rx_byte                                          | valid & ready
// frame   | out | frame_status, route, data_valid, data_byte,      | valid & ready
//         |     | data_index, last                                 |
// apb     | in  | max_payload_len at byte address 0                | psel & penable & pwrite
//
// Bytes are taken one per cycle while no frame is being reported.
// Frame end: a registered handoff, then a command fetch from the payload RAM when the
// payload has three or more bytes, then per result a RAM read, output load and
// transfer plus any sink stall. A failed or empty frame shows its single result in
// the cycle after the handoff. No byte after the LRC byte is taken until the last
// result of that frame has transferred. Synchronous reset clears the receive state and
// sets max_payload_len to 8; the payload RAM is not cleared.
`default_nettype none

module stx_etx_lrc_frame_receiver #(
  parameter int MAX_PAYLOAD = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  sxlrc_byte_if.sink                         rx,
  sxlrc_result_if.source                     frame,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [sxlrc_pkg::APB_AW-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import sxlrc_pkg::*;

  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
  localparam int IDX_W = $clog2(MAX_PAYLOAD);

  logic [3:0]       max_len;
  logic             busy;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [7:0]       wr_data;
  logic [IDX_W-1:0] rd_addr;
  logic [7:0]       rd_data;
  logic [CNT_W-1:0] byte_count;
  done_t            done;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_LEN) ? {28'd0, max_len} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_LEN) begin
      max_len <= pwdata[3:0];
    end
  end

  sxlrc_parse #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_parse (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .max_len    (max_len),
    .busy       (busy),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .byte_count (byte_count),
    .done       (done)
  );

  sxlrc_ram #(.WIDTH(8), .DEPTH(MAX_PAYLOAD)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sxlrc_emit #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_emit (
    .clk        (clk),
    .rst        (rst),
    .done       (done),
    .byte_count (byte_count),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .busy       (busy),
    .res        (frame)
  );

endmodule

`default_nettype wire

// ===== rtl/sxlrc_ram.sv =====
`default_nettype none

module sxlrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== rtl/sxlrc_parse.sv =====
`default_nettype none

module sxlrc_parse #(
  parameter int MAX_PAYLOAD = 8,
  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1),
  localparam int IDX_W = $clog2(MAX_PAYLOAD)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  sxlrc_byte_if.sink            rx,
  input  wire logic [3:0]       max_len,
  input  wire logic             busy,
  output logic                  wr_en,
  output logic [IDX_W-1:0]      wr_addr,
  output logic [7:0]            wr_data,
  output logic [CNT_W-1:0]      byte_count,
  output sxlrc_pkg::done_t      done
);
  import sxlrc_pkg::*;

  localparam int LW = (CNT_W > 4) ? CNT_W : 4;

  typedef enum logic [1:0] {
    HUNT,
    DATA,
    LRC
  } phase_t;

  phase_t      phase;
  logic [7:0]  running_lrc;
  logic        overflow;
  logic        accept;
  logic [LW-1:0] limit;
  logic        room;

  always_comb begin
    limit = LW'(max_len);
    if (max_len == 4'd0) begin
      limit = LW'(1);
    end else if (limit > LW'(MAX_PAYLOAD)) begin
      limit = LW'(MAX_PAYLOAD);
    end
  end

  assign room     = LW'(byte_count) < limit;
  assign rx.ready = !busy && !done.valid;
  assign accept   = rx.valid && rx.ready;

  assign wr_en   = accept && phase == DATA && rx.rx_byte != SYM_ETX && room;
  assign wr_addr = byte_count[IDX_W-1:0];
  assign wr_data = rx.rx_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= HUNT;
      byte_count  <= '0;
      running_lrc <= '0;
      overflow    <= 1'b0;
      done        <= '{valid: 1'b0, status: ST_OK};
    end else begin
      done.valid <= accept && phase == LRC;
      if (accept) begin
        case (phase)
          HUNT: begin
            if (rx.rx_byte == SYM_STX) begin
              phase       <= DATA;
              byte_count  <= '0;
              running_lrc <= '0;
              overflow    <= 1'b0;
            end
          end
          DATA: begin
            running_lrc <= running_lrc ^ rx.rx_byte;
            if (rx.rx_byte == SYM_ETX) begin
              phase <= LRC;
            end else if (room) begin
              byte_count <= byte_count + CNT_W'(1);
            end else begin
              overflow <= 1'b1;
            end
          end
          LRC: begin
            phase <= HUNT;
            if (overflow) begin
              done.status <= ST_TOO_LONG;
            end else if (rx.rx_byte != running_lrc) begin
              done.status <= ST_LRC_ERR;
            end else begin
              done.status <= ST_OK;
            end
          end
          default: begin
            phase <= HUNT;
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sxlrc_emit.sv =====
`default_nettype none

module sxlrc_emit #(
  parameter int MAX_PAYLOAD = 8,
  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1),
  localparam int IDX_W = $clog2(MAX_PAYLOAD)
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sxlrc_pkg::done_t  done,
  input  wire logic [CNT_W-1:0]  byte_count,
  output logic [IDX_W-1:0]       rd_addr,
  input  wire logic [7:0]        rd_data,
  output logic                   busy,
  sxlrc_result_if.source         res
);
  import sxlrc_pkg::*;

  localparam int CMP_W = CNT_W + 1;

  typedef enum logic [2:0] {
    IDLE,
    CMD_A,
    CMD_B,
    CLS,
    RDX,
    LOAD,
    SEND
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] idx;
  logic [7:0]       cmd_a;
  route_t           route;
  logic             is_last;

  assign busy    = state != IDLE;
  assign is_last = CMP_W'(idx) + CMP_W'(1) == CMP_W'(byte_count);

  always_comb begin
    case (state)
      CMD_A:   rd_addr = IDX_W'(1);
      CMD_B:   rd_addr = IDX_W'(2);
      default: rd_addr = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      res.valid <= 1'b0;
      idx       <= '0;
      route     <= RT_UNKNOWN;
    end else begin
      case (state)
        IDLE: begin
          idx <= '0;
          if (done.valid) begin
            if (done.status != ST_OK || byte_count == '0) begin
              res.valid        <= 1'b1;
              res.frame_status <= done.status;
              res.route        <= RT_UNKNOWN;
              res.data_valid   <= 1'b0;
              res.data_byte    <= '0;
              res.data_index   <= '0;
              res.last         <= 1'b1;
              state            <= SEND;
            end else if (CMP_W'(byte_count) < CMP_W'(3)) begin
              route <= RT_UNKNOWN;
              state <= RDX;
            end else begin
              state <= CMD_A;
            end
          end
        end
        CMD_A: begin
          state <= CMD_B;
        end
        CMD_B: begin
          cmd_a <= rd_data;
          state <= CLS;
        end
        CLS: begin
          route <= classify(cmd_a, rd_data);
          state <= RDX;
        end
        RDX: begin
          state <= LOAD;
        end
        LOAD: begin
          res.valid        <= 1'b1;
          res.frame_status <= ST_OK;
          res.route        <= route;
          res.data_valid   <= 1'b1;
          res.data_byte    <= rd_data;
          res.data_index   <= 3'(idx);
          res.last         <= is_last;
          state            <= SEND;
        end
        SEND: begin
          if (res.ready) begin
            res.valid <= 1'b0;
            if (res.last) begin
              state <= IDLE;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= RDX;
            end
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sxlrc_checker.sv =====
`default_nettype none
`include "stx_etx_lrc_frame_receiver_macros.svh"

module sxlrc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_status,
  input wire logic [1:0] out_route,
  input wire logic       out_data_valid,
  input wire logic [7:0] out_data_byte,
  input wire logic [2:0] out_data_index,
  input wire logic       out_last
);
  import sxlrc_pkg::*;

  `SXLRC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(out_data_byte) && $stable(out_last) && $stable(out_status),
    "result changed while stalled")

  `SXLRC_ASSERT_NOW(a_no_rx_while_reporting, clk, rst, out_valid, !in_ready,
    "byte taken while a result is pending")

  `SXLRC_ASSERT_NOW(a_single_result_form, clk, rst, out_valid && !out_data_valid,
    out_last && out_route == RT_UNKNOWN && out_data_byte == 8'd0 && out_data_index == 3'd0,
    "malformed single result")

  `SXLRC_ASSERT_NOW(a_fault_no_data, clk, rst, out_valid && out_status != ST_OK,
    !out_data_valid, "faulty frame carries data")

endmodule

bind stx_etx_lrc_frame_receiver sxlrc_checker u_chk (
  .clk            (clk),
  .rst            (rst),
  .in_ready       (rx.ready),
  .out_valid      (frame.valid),
  .out_ready      (frame.ready),
  .out_status     (frame.frame_status),
  .out_route      (frame.route),
  .out_data_valid (frame.data_valid),
  .out_data_byte  (frame.data_byte),
  .out_data_index (frame.data_index),
  .out_last       (frame.last)
);

`default_nettype wire
